// ===== hdl/dabd_pkg.sv =====
// ----------------------------------------------------------------------------
// dabd_pkg
// shared types, constants and the month length function for the date
// advance block
// ----------------------------------------------------------------------------
package dabd_pkg;

    localparam int DayW   = 5;
    localparam int MonthW = 4;
    localparam int YearW  = 14;
    localparam int AddW   = 16;
    // running day sum: up to 31 + 65535
    localparam int SumW   = 17;
    // year split into century and year within century
    localparam int CentW  = 8;
    localparam int RemW   = 7;

    localparam int InDataW  = 40;
    localparam int OutDataW = 24;

    localparam logic [YearW-1:0]  YearMax   = 14'd16383;
    localparam logic [12:0]       Recip100  = 13'd5243;   // 2^19 / 100, rounded up
    localparam int                RecipSh   = 19;
    localparam logic [RemW-1:0]   Hundred   = 7'd100;
    localparam logic [RemW-1:0]   RemLast   = 7'd99;
    localparam logic [MonthW:0]   MonthDec  = 5'd12;
    localparam logic [MonthW-1:0] MonthJan  = 4'd1;
    localparam logic [MonthW-1:0] MonthFeb  = 4'd2;
    localparam logic [MonthW-1:0] MonthApr  = 4'd4;
    localparam logic [MonthW-1:0] MonthJun  = 4'd6;
    localparam logic [MonthW-1:0] MonthSep  = 4'd9;
    localparam logic [MonthW-1:0] MonthNov  = 4'd11;
    localparam logic [DayW-1:0]   LenLeap   = 5'd29;
    localparam logic [DayW-1:0]   LenFeb    = 5'd28;
    localparam logic [DayW-1:0]   LenShort  = 5'd30;
    localparam logic [DayW-1:0]   LenLong   = 5'd31;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;   // capture the request
        logic div;    // split the year: century quotient
        logic rem;    // split the year: year within century
        logic step;   // subtract one month and advance
        logic emit;   // copy the date into the output register
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic more;   // day still exceeds current month length
    } t_dp_sts;

    // days in a month; unknown month codes count as long months
    function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] month,
                                                  input logic leap);
        logic [DayW-1:0] len;
        len = LenLong;
        unique case (month)
            MonthFeb: len = leap ? LenLeap : LenFeb;
            MonthApr, MonthJun, MonthSep, MonthNov: len = LenShort;
            default:  len = LenLong;
        endcase
        return len;
    endfunction

endpackage

// ===== hdl/dabd_datapath.sv =====
// ----------------------------------------------------------------------------
// dabd_datapath
// date registers, year split for the leap test, month step unit and the
// output register
// ----------------------------------------------------------------------------
module dabd_datapath import dabd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic [DayW-1:0]     i_day,
    input  logic [MonthW-1:0]   i_month,
    input  logic [YearW-1:0]    i_year,
    input  logic [AddW-1:0]     i_add,
    output t_dp_sts             o_sts,
    output logic [DayW-1:0]     o_day,
    output logic [MonthW-1:0]   o_month,
    output logic [YearW-1:0]    o_year
);

    logic [SumW-1:0]   r_day;
    logic [MonthW-1:0] r_month;
    logic [YearW-1:0]  r_year;
    logic [CentW-1:0]  r_cent;
    logic [RemW-1:0]   r_rem;
    logic [1:0]        r_cent4;
    logic [DayW-1:0]   r_day_o;
    logic [MonthW-1:0] r_month_o;
    logic [YearW-1:0]  r_year_o;

    logic [26:0]       w_prod;
    logic [YearW:0]    w_hund;
    logic [YearW-1:0]  w_diff;
    logic              w_leap;
    logic [DayW-1:0]   w_len;
    logic [MonthW:0]   w_mnext;
    logic              w_wrap;
    logic              w_ywrap;

    // year / 100 by reciprocal, exact for 14-bit years
    assign w_prod = r_year * Recip100;
    assign w_hund = r_cent * Hundred;
    assign w_diff = r_year - w_hund[YearW-1:0];

    // gregorian leap rule from the split year
    assign w_leap = (r_year[1:0] == 2'd0) && ((r_rem != '0) || (r_cent4 == 2'd0));
    assign w_len  = month_len(r_month, w_leap);

    assign o_sts.more = (r_day > {{(SumW-DayW){1'b0}}, w_len});

    // month step with december wrap
    assign w_mnext = {1'b0, r_month} + 5'd1;
    assign w_wrap  = (w_mnext > MonthDec);
    assign w_ywrap = (r_year == YearMax);

    // working date
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_day   <= {{(SumW-DayW){1'b0}}, i_day} + {1'b0, i_add};
            r_month <= i_month;
            r_year  <= i_year;
        end else if (i_cmd.step) begin
            r_day <= r_day - {{(SumW-DayW){1'b0}}, w_len};
            if (w_wrap) begin
                r_month <= MonthJan;
                r_year  <= r_year + 14'd1;
            end else begin
                r_month <= w_mnext[MonthW-1:0];
            end
        end
    end

    // year split kept in step with the year counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.div) begin
            r_cent <= w_prod[RecipSh +: CentW];
        end
        if (i_cmd.rem) begin
            r_rem   <= w_diff[RemW-1:0];
            r_cent4 <= r_cent[1:0];
        end else if (i_cmd.step && w_wrap) begin
            if (w_ywrap) begin
                r_rem   <= '0;
                r_cent4 <= 2'd0;
            end else if (r_rem == RemLast) begin
                r_rem   <= '0;
                r_cent4 <= r_cent4 + 2'd1;
            end else begin
                r_rem <= r_rem + 7'd1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_day_o   <= r_day[DayW-1:0];
            r_month_o <= r_month;
            r_year_o  <= r_year;
        end
    end

    assign o_day   = r_day_o;
    assign o_month = r_month_o;
    assign o_year  = r_year_o;

    // a month step always shrinks the day
    a_step_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> (r_day < $past(r_day)))
        else $error("day did not shrink on month step");

    // year within century stays below one hundred once split
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_rem <= RemLast))
        else $error("year within century out of range");

    // emitted day matches the working day
    a_emit_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_day_o == $past(r_day[DayW-1:0])))
        else $error("output day mismatch");

endmodule

// ===== hdl/dabd_ctrl.sv =====
// ----------------------------------------------------------------------------
// dabd_ctrl
// controller: request intake, year split sequence, month loop and
// result hand-off
// ----------------------------------------------------------------------------
module dabd_ctrl import dabd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_REM  = 3'd2;
    localparam logic [2:0] S_RUN  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_free;

    assign w_free     = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = S_REM;
            end
            S_REM: begin
                o_cmd.rem = 1'b1;
                n_state   = S_RUN;
            end
            S_RUN: begin
                if (i_sts.more) begin
                    o_cmd.step = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // an accepted request starts the year split
    a_accept_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DIV))
        else $error("request not followed by year split");

    // at most one command per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("several datapath commands at once");

    // loop ends exactly when the day fits the month
    a_run_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && !i_sts.more) |=> (r_state == S_DONE))
        else $error("month loop did not finish");

    // an emitted result is presented next cycle
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> r_out_valid)
        else $error("emitted result not valid");

endmodule

// ===== hdl/date_advance_by_days.sv =====
// ----------------------------------------------------------------------------
// date_advance_by_days
// gregorian date advance: start date plus a day count gives the later date
// ----------------------------------------------------------------------------
// A request is loaded on acceptance, the year is split into century and year
// within century for the leap test (div, then rem), and the month loop then
// takes one month step per cycle for each of the N months the day sum crosses
// (at most about 2160 for 65535 days plus a day of 31) before the result can
// be registered. The loop is set by the single month subtract-and-step unit;
// the year split happens once per request. A new request is taken as soon as the
// previous one has moved into the output register, even while that result
// still waits on the output side. Reset clears the controller only.
module date_advance_by_days import dabd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // day_in[4:0], month_in[8:5], year_in[22:9], days_to_add[38:23], zero pad
    input  logic [InDataW-1:0]  s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // day_out[4:0], month_out[8:5], year_out[22:9], zero pad
    output logic [OutDataW-1:0] m_axis_tdata
);

    t_dp_cmd           w_cmd;
    t_dp_sts           w_sts;
    logic [DayW-1:0]   w_day;
    logic [MonthW-1:0] w_month;
    logic [YearW-1:0]  w_year;

    // controller
    dabd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // datapath
    dabd_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_day   (s_axis_tdata[4:0]),
        .i_month (s_axis_tdata[8:5]),
        .i_year  (s_axis_tdata[22:9]),
        .i_add   (s_axis_tdata[38:23]),
        .o_sts   (w_sts),
        .o_day   (w_day),
        .o_month (w_month),
        .o_year  (w_year)
    );

    assign m_axis_tdata = {1'b0, w_year, w_month, w_day};

endmodule

// ===== bench/date_advance_by_days_chk.sv =====
// ----------------------------------------------------------------------------
// date_advance_by_days_chk
// watches both stream channels of the date advance block, works out the
// advanced date for every accepted request and compares it, field by field,
// with the results in the order they leave the block
// ----------------------------------------------------------------------------
module date_advance_by_days_chk import dabd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    // day_in[4:0], month_in[8:5], year_in[22:9], days_to_add[38:23], zero pad
    input  logic [InDataW-1:0]  i_s_tdata,
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    // day_out[4:0], month_out[8:5], year_out[22:9], zero pad
    input  logic [OutDataW-1:0] i_m_tdata,
    output int                  o_fail_count,
    output int                  o_pending
);

    typedef struct packed {
        logic [YearW-1:0]  year;
        logic [MonthW-1:0] month;
        logic [DayW-1:0]   day;
    } t_date;

    t_date due_dates_q[$];
    int    mismatches = 0;

    // gregorian month length, months outside 1..12 count as long
    function automatic int unsigned days_in_month(input int unsigned month,
                                                  input int unsigned year);
        bit leap;
        leap = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
        if (month == MonthFeb)
            return leap ? 29 : 28;
        if (month == MonthApr || month == MonthJun || month == MonthSep || month == MonthNov)
            return 30;
        return 31;
    endfunction

    // add the days, then strip whole months off the day sum one at a time
    function automatic t_date advance_date(input logic [DayW-1:0]   day0,
                                           input logic [MonthW-1:0] month0,
                                           input logic [YearW-1:0]  year0,
                                           input logic [AddW-1:0]   add);
        int unsigned day;
        int unsigned month;
        int unsigned year;
        int unsigned len;
        t_date       res;
        day   = int'(day0) + int'(add);
        month = month0;
        year  = year0;
        len   = days_in_month(month, year);
        while (day > len) begin
            day   -= len;
            month += 1;
            if (month > 12) begin
                month = 1;
                // year counter wraps at its width
                year  = (year + 1) % (1 << YearW);
            end
            len = days_in_month(month, year);
        end
        res.day   = day[DayW-1:0];
        res.month = month[MonthW-1:0];
        res.year  = year[YearW-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // sample both channels at the rising edge
    always @(posedge i_clk) begin
        t_date got;
        t_date want;
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[DayW+MonthW+YearW-1:0];
                if (due_dates_q.size() == 0) begin
                    report_mismatch("unexpected result, day", got.day, 0);
                end else begin
                    want = due_dates_q.pop_front();
                    if (got.day !== want.day)
                        report_mismatch("day_out", got.day, want.day);
                    if (got.month !== want.month)
                        report_mismatch("month_out", got.month, want.month);
                    if (got.year !== want.year)
                        report_mismatch("year_out", got.year, want.year);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                due_dates_q.push_back(advance_date(i_s_tdata[4:0], i_s_tdata[8:5],
                                                   i_s_tdata[22:9], i_s_tdata[38:23]));
            end
        end
        o_pending    = due_dates_q.size();
        o_fail_count = mismatches;
    end

endmodule

// ===== bench/date_advance_by_days_tb.sv =====
// ----------------------------------------------------------------------------
// date_advance_by_days_tb
// drives start dates and day counts into the date advance block, with random
// gaps and stalls on both sides, a long output hold-off and a full drain;
// the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module date_advance_by_days_tb;
    import dabd_pkg::*;

    localparam int CycleLimit  = 3_000_000;
    localparam int HoldCycles  = 300;
    localparam int DrainCycles = 100;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    // day_in[4:0], month_in[8:5], year_in[22:9], days_to_add[38:23], zero pad
    logic [InDataW-1:0]  s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    // day_out[4:0], month_out[8:5], year_out[22:9], zero pad
    logic [OutDataW-1:0] m_axis_tdata;

    int chk_fail_count;
    int chk_pending;
    int cycle_count = 0;

    // idle controls, changed by the stimulus with nonblocking writes
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit rx_hold_req = 1'b0;

    date_advance_by_days u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    date_advance_by_days_chk u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_fail_count (chk_fail_count),
        .o_pending    (chk_pending)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side ready: random stalls, one long hold-off on request
    initial begin : rx_ready
        int hold_left;
        bit held;
        hold_left     = 0;
        held          = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req && !held) begin
                held      = 1'b1;
                hold_left = HoldCycles;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (rx_idle_on) begin
                m_axis_tready <= ($urandom_range(99) >= 28);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // offer one request and hold it until accepted, with random gaps before
    task automatic send_date(input logic [DayW-1:0]   day,
                             input logic [MonthW-1:0] month,
                             input logic [YearW-1:0]  year,
                             input logic [AddW-1:0]   add);
        while (tx_idle_on && $urandom_range(99) < 28) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, add, year, month, day};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // mostly calendar dates and modest counts, some raw field values and
    // a few very long advances
    task automatic send_random_date(input int max_add);
        logic [DayW-1:0]   day;
        logic [MonthW-1:0] month;
        logic [YearW-1:0]  year;
        logic [AddW-1:0]   add;
        int                pick;
        pick = $urandom_range(99);
        if (pick < 80) begin
            day   = DayW'($urandom_range(1, 31));
            month = MonthW'($urandom_range(1, 12));
            year  = YearW'($urandom_range(0, 9999));
        end else begin
            day   = DayW'($urandom_range(0, 31));
            month = MonthW'($urandom_range(0, 15));
            year  = YearW'($urandom_range(0, 16383));
        end
        pick = $urandom_range(99);
        if (pick < 85 || max_add <= 400)
            add = AddW'($urandom_range(0, (max_add < 400) ? max_add : 400));
        else if (pick < 95)
            add = AddW'($urandom_range(0, 5000));
        else
            add = AddW'($urandom_range(0, max_add));
        send_date(day, month, year, add);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: plain dates, extremes and odd field values
        send_date(5'd1,  4'd1,  14'd2000,  16'd0);
        send_date(5'd31, 4'd12, 14'd9999,  16'd0);
        send_date(5'd31, 4'd12, 14'd9999,  16'd1);
        send_date(5'd31, 4'd4,  14'd2023,  16'd0);      // day past month end
        send_date(5'd29, 4'd2,  14'd2023,  16'd0);
        send_date(5'd0,  4'd6,  14'd2021,  16'd0);      // day zero stays zero
        send_date(5'd0,  4'd3,  14'd2020,  16'd1);
        send_date(5'd0,  4'd0,  14'd0,     16'd0);
        send_date(5'd15, 4'd0,  14'd2020,  16'd20);     // month zero steps to 1
        send_date(5'd10, 4'd13, 14'd2020,  16'd40);     // month above december
        send_date(5'd31, 4'd15, 14'd16383, 16'd1);      // year wraps to zero
        send_date(5'd28, 4'd2,  14'd2000,  16'd1);      // 400-year leap
        send_date(5'd28, 4'd2,  14'd1900,  16'd1);      // century, not leap
        send_date(5'd28, 4'd2,  14'd2024,  16'd1);
        send_date(5'd28, 4'd2,  14'd2023,  16'd1);
        send_date(5'd1,  4'd2,  14'd2100,  16'd28);
        send_date(5'd30, 4'd11, 14'd2020,  16'd31);
        send_date(5'd31, 4'd1,  14'd9999,  16'd365);
        send_date(5'd1,  4'd1,  14'd0,     16'd65535);
        send_date(5'd31, 4'd12, 14'd16383, 16'd65535);
        send_date(5'd31, 4'd15, 14'd16383, 16'd65535);

        // random, no idling on either side
        tx_idle_on <= 1'b0;
        rx_idle_on <= 1'b0;
        repeat (60) send_random_date(65535);

        // long output hold-off while requests keep coming
        tx_idle_on  <= 1'b1;
        rx_idle_on  <= 1'b1;
        rx_hold_req <= 1'b1;
        repeat (20) send_random_date(60);

        // sender pauses until every result is out
        s_axis_tvalid <= 1'b0;
        while (chk_pending != 0) @(negedge i_clk);

        // random with idling on both sides
        repeat (150) send_random_date(65535);

        s_axis_tvalid <= 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);

        if (chk_fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== date_advance_by_days.f =====
hdl/dabd_pkg.sv
hdl/dabd_datapath.sv
hdl/dabd_ctrl.sv
hdl/date_advance_by_days.sv
bench/date_advance_by_days_chk.sv
bench/date_advance_by_days_tb.sv
